### src/eau_pkg.sv
// ----------------------------------------------------------------------------
// eau_pkg
// Shared constants and types of the error function unit: Q.30 coefficients,
// constant reciprocals and pipeline latencies.
// ----------------------------------------------------------------------------
package eau_pkg;

    localparam int EXP_LAT    = 57;
    localparam int RECIP_LAT  = 35;
    localparam int HORNER_LAT = 15;
    localparam int FINAL_LAT  = 5;
    localparam int POLY_DLY   = EXP_LAT - RECIP_LAT - HORNER_LAT;
    localparam int TOTAL_LAT  = EXP_LAT + FINAL_LAT;

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [15:0] LN2_RECIP = 16'd47274;

    localparam logic [16:0] P_HI    = 17'd85876;
    localparam logic [11:0] P_LO    = 12'd3228;
    localparam logic [15:0] P_RND   = 16'd39062;
    localparam logic [27:0] P_RECIP = 28'd225179981;
    localparam logic [16:0] P_DIV   = 17'd78125;

    localparam logic signed [33:0] COEF_A5 = 34'sd1139675401;
    localparam logic signed [33:0] HORNER_COEF [0:4] = '{
        -34'sd1560310108,
         34'sd1526231383,
        -34'sd305476044,
         34'sd273621191,
         34'sd0
    };

    localparam logic [32:0] TWO_SQRTPI_Q30 = 33'd1211587905;

    localparam logic [32:0] RECIP_N [0:16] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
        33'd330382099,  33'd306783378,  33'd286331153,  33'd268435456,
        33'd252645135
    };

    typedef struct packed {
        logic action;
        logic neg;
    } ctl_t;

endpackage

### src/eau_exp.sv
// ----------------------------------------------------------------------------
// eau_exp
// exp(-a*a) in Q.30: square, range reduction by ln2, seventeen-term series
// with one term per three stages, final power-of-two scaling.
// ----------------------------------------------------------------------------
module eau_exp (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] a_in,
    output logic [30:0] e_out
);

    typedef struct packed {
        logic [29:0] r;
        logic [6:0]  k;
        logic        zero;
    } side_t;

    logic [31:0] sq_full;
    logic [30:0] sq_next, sq_reg;
    logic [46:0] kprod;
    logic [6:0]  k0_next, k0_reg, k0b_reg;
    logic [36:0] s30_next, s30_reg, s30b_reg;
    logic        zero_next, zero_reg, zerob_reg;
    logic [36:0] kl_next, kl_reg;
    logic [36:0] r0;
    logic        corr;
    side_t       sd_next, sd_reg;

    assign sq_full   = {16'd0, a_in} * {16'd0, a_in};
    assign sq_next   = sq_full[30:0];
    assign kprod     = {16'd0, sq_reg} * {31'd0, eau_pkg::LN2_RECIP};
    assign k0_next   = kprod[45:39];
    assign s30_next  = {sq_reg, 6'd0};
    assign zero_next = sq_reg[30] | sq_reg[29];
    assign kl_next   = {30'd0, k0_reg} * {7'd0, eau_pkg::LN2_Q30};
    assign r0        = s30b_reg - kl_reg;
    assign corr      = r0 >= {7'd0, eau_pkg::LN2_Q30};

    always_comb begin
        sd_next.zero = zerob_reg;
        if (corr) begin
            sd_next.r = 30'(r0 - {7'd0, eau_pkg::LN2_Q30});
            sd_next.k = k0b_reg + 7'd1;
        end else begin
            sd_next.r = r0[29:0];
            sd_next.k = k0b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg    <= sq_next;
            k0_reg    <= k0_next;
            s30_reg   <= s30_next;
            zero_reg  <= zero_next;
            k0b_reg   <= k0_reg;
            s30b_reg  <= s30_reg;
            zerob_reg <= zero_reg;
            kl_reg    <= kl_next;
            sd_reg    <= sd_next;
        end
    end

    logic [59:0]        prod_reg [0:16];
    logic signed [32:0] acca_reg [0:16];
    side_t              sa_reg   [0:16];
    logic [30:0]        y_reg    [0:16];
    logic [63:0]        ym_reg   [0:16];
    logic signed [32:0] accb_reg [0:16];
    side_t              sb_reg   [0:16];
    logic [30:0]        term_reg [0:16];
    logic signed [32:0] accc_reg [0:16];
    side_t              sc_reg   [0:16];

    for (genvar j = 0; j < 17; j++) begin : g_term
        logic [30:0]        term_in;
        logic signed [32:0] acc_in;
        side_t              s_in;
        logic [59:0]        prod_next;
        logic signed [32:0] acc_next;
        logic [31:0]        ysum;
        logic [30:0]        y_next;
        logic [63:0]        ym_next;
        logic [30:0]        q0;
        logic [31:0]        qn;
        logic [31:0]        rem;
        logic [30:0]        term_next;

        if (j == 0) begin : g_first
            assign term_in = 31'd1 << 30;
            assign acc_in  = 33'sd1 <<< 30;
            assign s_in    = sd_reg;
            assign acc_next = acc_in;
        end else begin : g_rest
            assign term_in = term_reg[j-1];
            assign acc_in  = accc_reg[j-1];
            assign s_in    = sc_reg[j-1];
            if (j % 2 == 1) begin : g_sub
                assign acc_next = acc_in - $signed({2'd0, term_in});
            end else begin : g_add
                assign acc_next = acc_in + $signed({2'd0, term_in});
            end
        end

        assign prod_next = {29'd0, term_in} * {30'd0, s_in.r};
        assign ysum      = {1'b0, prod_reg[j][59:29]} + 32'(j + 1);
        assign y_next    = ysum[31:1];
        assign ym_next   = {33'd0, y_next} * {31'd0, eau_pkg::RECIP_N[j]};
        assign q0        = ym_reg[j][62:32];
        assign qn        = {1'b0, q0} * 32'(j + 1);
        assign rem       = {1'b0, y_reg[j]} - qn;
        assign term_next = (rem >= 32'(j + 1)) ? q0 + 31'd1 : q0;

        always_ff @(posedge aclk) begin
            if (en) begin
                prod_reg[j] <= prod_next;
                acca_reg[j] <= acc_next;
                sa_reg[j]   <= s_in;
                y_reg[j]    <= y_next;
                ym_reg[j]   <= ym_next;
                accb_reg[j] <= acca_reg[j];
                sb_reg[j]   <= sa_reg[j];
                term_reg[j] <= term_next;
                accc_reg[j] <= accb_reg[j];
                sc_reg[j]   <= sb_reg[j];
            end
        end
    end

    logic signed [32:0] accf;
    logic [30:0]        accf_next, accf_reg;
    side_t              sf_reg;
    logic [32:0]        rnd_sum;
    logic [5:0]         sh;
    logic [30:0]        e_next;

    assign accf      = accc_reg[16] - $signed({2'd0, term_reg[16]});
    assign accf_next = (accf < 0) ? 31'd0 : accf[30:0];
    assign sh        = sf_reg.k[5:0];

    always_comb begin
        rnd_sum = 33'd0;
        if (sf_reg.zero || sf_reg.k > 7'd31) begin
            e_next = 31'd0;
        end else if (sf_reg.k == 7'd0) begin
            e_next = accf_reg;
        end else begin
            rnd_sum = {2'd0, accf_reg} + (33'd1 << (sh - 6'd1));
            e_next  = 31'(rnd_sum >> sh);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            accf_reg <= accf_next;
            sf_reg   <= sc_reg[16];
            e_out    <= e_next;
        end
    end

endmodule

### src/eau_recip.sv
// ----------------------------------------------------------------------------
// eau_recip
// t = round(1 / (1 + p*a)) in Q.30: scaled product by constant reciprocal,
// then a restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module eau_recip (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] a_in,
    output logic [30:0] t_out
);

    logic [26:0] z_next, z_reg, zb_reg;
    logic [31:0] base_next, base_reg, baseb_reg, basec_reg;
    logic [54:0] zm_next, zm_reg;
    logic [10:0] q0;
    logic [27:0] qn;
    logic [27:0] rem;
    logic [10:0] q_next, q_reg;
    logic [31:0] u_next, u_reg;

    assign z_next    = 27'({11'd0, a_in} * {15'd0, eau_pkg::P_LO}) + {11'd0, eau_pkg::P_RND};
    assign base_next = {16'd0, a_in} * {15'd0, eau_pkg::P_HI};
    assign zm_next   = {28'd0, z_reg} * {27'd0, eau_pkg::P_RECIP};
    assign q0        = zm_reg[54:44];
    assign qn        = {17'd0, q0} * {11'd0, eau_pkg::P_DIV};
    assign rem       = {1'b0, zb_reg} - qn;
    assign q_next    = (rem >= {11'd0, eau_pkg::P_DIV}) ? q0 + 11'd1 : q0;
    assign u_next    = (32'd1 << 30) + basec_reg + {21'd0, q_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg     <= z_next;
            base_reg  <= base_next;
            zm_reg    <= zm_next;
            zb_reg    <= z_reg;
            baseb_reg <= base_reg;
            q_reg     <= q_next;
            basec_reg <= baseb_reg;
            u_reg     <= u_next;
        end
    end

    logic [31:0] dr_reg [0:30];
    logic [31:0] du_reg [0:30];
    logic [30:0] dq_reg [0:30];

    for (genvar s = 0; s < 31; s++) begin : g_div
        logic [31:0] r_in;
        logic [31:0] u_in;
        logic [30:0] q_in;
        logic [32:0] rs;
        logic        ge;
        logic [31:0] r_next;
        logic [30:0] dq_next;

        if (s == 0) begin : g_first
            assign r_in = 32'd1 << 29;
            assign u_in = u_reg;
            assign q_in = 31'd0;
        end else begin : g_rest
            assign r_in = dr_reg[s-1];
            assign u_in = du_reg[s-1];
            assign q_in = dq_reg[s-1];
        end

        assign rs      = {r_in, u_in[31-s]};
        assign ge      = rs >= {1'b0, u_in};
        assign r_next  = ge ? 32'(rs - {1'b0, u_in}) : rs[31:0];
        assign dq_next = {q_in[29:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                dr_reg[s] <= r_next;
                du_reg[s] <= u_in;
                dq_reg[s] <= dq_next;
            end
        end
    end

    assign t_out = dq_reg[30];

endmodule

### src/eau_horner.sv
// ----------------------------------------------------------------------------
// eau_horner
// Five-step Horner evaluation of the rational polynomial in t, Q.30,
// three stages per step: magnitude, product, round and add.
// ----------------------------------------------------------------------------
module eau_horner (
    input  logic               aclk,
    input  logic               en,
    input  logic [30:0]        t_in,
    output logic signed [33:0] poly_out
);

    logic [32:0]        mag_reg [0:4];
    logic               sa_reg  [0:4];
    logic [30:0]        ta_reg  [0:4];
    logic [63:0]        m_reg   [0:4];
    logic               sb_reg  [0:4];
    logic [30:0]        tb_reg  [0:4];
    logic signed [33:0] x_reg   [0:4];
    logic [30:0]        tc_reg  [0:4];

    for (genvar s = 0; s < 5; s++) begin : g_step
        logic signed [33:0] x_in;
        logic [30:0]        t_cur;
        logic [33:0]        neg_x;
        logic [32:0]        mag_next;
        logic [63:0]        m_next;
        logic [35:0]        psum;
        logic signed [35:0] p;
        logic signed [35:0] x_wide;

        if (s == 0) begin : g_first
            assign x_in  = eau_pkg::COEF_A5;
            assign t_cur = t_in;
        end else begin : g_rest
            assign x_in  = x_reg[s-1];
            assign t_cur = tc_reg[s-1];
        end

        assign neg_x    = -x_in;
        assign mag_next = x_in[33] ? neg_x[32:0] : x_in[32:0];
        assign m_next   = {31'd0, mag_reg[s]} * {33'd0, ta_reg[s]};
        assign psum     = {1'b0, m_reg[s][63:29]} + 36'd1;
        assign p        = $signed({1'b0, psum[35:1]});
        assign x_wide   = 36'(eau_pkg::HORNER_COEF[s]) + (sb_reg[s] ? -p : p);

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[s] <= mag_next;
                sa_reg[s]  <= x_in[33];
                ta_reg[s]  <= t_cur;
                m_reg[s]   <= m_next;
                sb_reg[s]  <= sa_reg[s];
                tb_reg[s]  <= ta_reg[s];
                x_reg[s]   <= x_wide[33:0];
                tc_reg[s]  <= tb_reg[s];
            end
        end
    end

    assign poly_out = x_reg[4];

endmodule

### src/eau_final.sv
// ----------------------------------------------------------------------------
// eau_final
// Product with exp(-z*z), complement for erf, round to Q1.14, saturate to
// one and restore the sign of negative arguments in erf mode.
// ----------------------------------------------------------------------------
module eau_final (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [33:0] poly_in,
    input  logic [30:0]        e_in,
    input  eau_pkg::ctl_t      ctl_in,
    output logic signed [15:0] result_out
);

    logic [33:0]        neg_poly;
    logic [32:0]        mag_next, mag_reg;
    logic               sg_next, sg_reg, sgb_reg;
    logic [30:0]        e_reg;
    eau_pkg::ctl_t      c1_reg, c2_reg, c3_reg, c4_reg;
    logic [63:0]        m_next, m_reg;
    logic [35:0]        psum;
    logic signed [36:0] p;
    logic signed [36:0] sp;
    logic signed [36:0] q_next, q_reg;
    logic [36:0]        rsum;
    logic [20:0]        rnd_next, rnd_reg;
    logic [15:0]        sat;
    logic [15:0]        res_next;

    assign neg_poly = -poly_in;
    assign mag_next = ctl_in.action ? eau_pkg::TWO_SQRTPI_Q30
                    : (poly_in[33] ? neg_poly[32:0] : poly_in[32:0]);
    assign sg_next  = !ctl_in.action && poly_in[33];
    assign m_next   = {31'd0, mag_reg} * {33'd0, e_reg};
    assign psum     = {1'b0, m_reg[63:29]} + 36'd1;
    assign p        = $signed({2'b0, psum[35:1]});
    assign sp       = sgb_reg ? -p : p;
    assign q_next   = c2_reg.action ? p : (37'sd1 <<< 30) - sp;
    assign rsum     = q_reg + 37'sd32768;
    assign rnd_next = q_reg[36] ? 21'd0 : rsum[36:16];
    assign sat      = (rnd_reg > 21'd16384) ? 16'd16384 : rnd_reg[15:0];
    assign res_next = (!c4_reg.action && c4_reg.neg) ? -sat : sat;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg    <= mag_next;
            sg_reg     <= sg_next;
            e_reg      <= e_in;
            c1_reg     <= ctl_in;
            m_reg      <= m_next;
            sgb_reg    <= sg_reg;
            c2_reg     <= c1_reg;
            q_reg      <= q_next;
            c3_reg     <= c2_reg;
            rnd_reg    <= rnd_next;
            c4_reg     <= c3_reg;
            result_out <= $signed(res_next);
        end
    end

endmodule

### src/erf_approximation_unit_top.sv
// ----------------------------------------------------------------------------
// erf_approximation_unit_top
// Error function or its derivative of a Q3.12 argument, result in Q1.14.
//
// Input channel s_valid/s_ready carries s_action (0 erf, 1 derivative) and
// s_arg_z. Result channel m_valid/m_ready carries m_result_value, saturated
// to plus or minus one.
// One item enters every cycle while s_ready is high; the path from acceptance
// to m_valid runs through the seventeen-term exponential series (three stages a
// term) and the final product, rounding and saturation stages.
// The reciprocal divider (one quotient bit a stage) and the Horner chain run
// alongside the exponential and are delay-matched to it.
// When the receiver stalls, one item is held in the output register and
// the next in a skid register; s_ready drops only when both are occupied,
// and the whole pipeline holds until the skid register drains.
// Reset clears all valid bits and empties the output side; no item in
// flight survives it.
// ----------------------------------------------------------------------------
module erf_approximation_unit_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [15:0] s_arg_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_result_value
);

    logic               en;
    logic [15:0]        neg_z;
    logic [15:0]        a_abs;
    eau_pkg::ctl_t      ctl_in;
    eau_pkg::ctl_t      ctl_reg [0:eau_pkg::EXP_LAT-1];
    logic               v_reg   [0:eau_pkg::TOTAL_LAT-1];
    logic signed [33:0] pd_reg  [0:eau_pkg::POLY_DLY-1];
    logic [30:0]        e_val;
    logic [30:0]        t_val;
    logic signed [33:0] poly;
    logic signed [15:0] res;
    logic               incoming;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_data_reg, m_data_next;
    logic               skid_valid_reg, skid_valid_next;
    logic signed [15:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign neg_z    = -s_arg_z;
    assign a_abs    = s_arg_z[15] ? neg_z : s_arg_z;
    assign ctl_in   = '{action: s_action, neg: s_arg_z[15]};
    assign incoming = en && v_reg[eau_pkg::TOTAL_LAT-1];

    eau_exp u_exp (
        .aclk  (aclk),
        .en    (en),
        .a_in  (a_abs),
        .e_out (e_val)
    );

    eau_recip u_recip (
        .aclk  (aclk),
        .en    (en),
        .a_in  (a_abs),
        .t_out (t_val)
    );

    eau_horner u_horner (
        .aclk     (aclk),
        .en       (en),
        .t_in     (t_val),
        .poly_out (poly)
    );

    eau_final u_final (
        .aclk       (aclk),
        .en         (en),
        .poly_in    (pd_reg[eau_pkg::POLY_DLY-1]),
        .e_in       (e_val),
        .ctl_in     (ctl_reg[eau_pkg::EXP_LAT-1]),
        .result_out (res)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < eau_pkg::EXP_LAT; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            pd_reg[0] <= poly;
            for (int i = 1; i < eau_pkg::POLY_DLY; i++) begin
                pd_reg[i] <= pd_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < eau_pkg::TOTAL_LAT; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid;
            for (int i = 1; i < eau_pkg::TOTAL_LAT; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // drain skid first, then take the pipeline's item
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = incoming;
                m_data_next  = res;
            end
        end else if (incoming) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (m_valid_reg && !m_ready && incoming) begin
            skid_data_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_data_reg;

endmodule
